### hw/rtl/casp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casp_pkg
// Shared types, codes and hash constants for the clock anchor sideband parser.
// ----------------------------------------------------------------------------
package casp_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [2:0] REQ_BEGIN   = 3'd0;
	localparam logic [2:0] REQ_END     = 3'd1;
	localparam logic [2:0] REQ_SETTING = 3'd2;
	localparam logic [2:0] REQ_SERVICE = 3'd3;
	localparam logic [2:0] REQ_CONSUME = 3'd4;

	// Parse phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_FRAME  = 3'd1;
	localparam logic [2:0] PH_TLO    = 3'd2;
	localparam logic [2:0] PH_THI    = 3'd3;
	localparam logic [2:0] PH_CHECK  = 3'd4;
	localparam logic [2:0] PH_COMMIT = 3'd5;
	localparam logic [2:0] PH_READY  = 3'd6;
	localparam logic [2:0] PH_POISON = 3'd7;

	// Result status codes.
	localparam logic [3:0] ST_INV_ARG      = 4'd0;
	localparam logic [3:0] ST_INV_STATE    = 4'd1;
	localparam logic [3:0] ST_STARTED      = 4'd2;
	localparam logic [3:0] ST_BOUNDARY     = 4'd3;
	localparam logic [3:0] ST_ENDED        = 4'd4;
	localparam logic [3:0] ST_NOT_SIDEBAND = 4'd5;
	localparam logic [3:0] ST_INTERVENING  = 4'd6;
	localparam logic [3:0] ST_UNEXPECTED   = 4'd7;
	localparam logic [3:0] ST_BAD_VERSION  = 4'd8;
	localparam logic [3:0] ST_ACCEPTED     = 4'd9;
	localparam logic [3:0] ST_CHECK_BAD    = 4'd10;
	localparam logic [3:0] ST_COMMIT_BAD   = 4'd11;
	localparam logic [3:0] ST_COMMITTED    = 4'd12;
	localparam logic [3:0] ST_MISSING      = 4'd13;
	localparam logic [3:0] ST_MISMATCH     = 4'd14;
	localparam logic [3:0] ST_MATCHED      = 4'd15;

	// Configuration register indexes.
	localparam logic REG_SCHEMA = 1'b0;
	localparam logic REG_BASE   = 1'b1;

	// Sideband offsets from the base index.
	localparam logic [31:0] OFF_CHECK  = 32'd4;
	localparam logic [31:0] OFF_COMMIT = 32'd5;
	localparam logic [31:0] OFF_LAST   = 32'd5;

	localparam logic [31:0] HASH_BASIS    = 32'd2166136261;
	localparam logic [31:0] HASH_MULT     = 32'd16777619;
	localparam logic [31:0] CHECK_DOMAIN  = 32'h44434c31;
	localparam logic [31:0] COMMIT_DOMAIN = 32'h44434331;
	localparam logic [7:0]  BYTE_MASK     = 8'hff;

	// Bytes hashed at run time: version, frame, time low, time high.
	localparam int HASH_BYTES = 16;
	localparam int BYTE_SEL_W = $clog2(HASH_BYTES);

	function automatic logic [31:0] fnv_word(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] acc;
		acc = h;
		for (int k = 0; k < 4; k++) begin
			acc = (acc ^ {24'b0, w[k*8 +: 8] & BYTE_MASK}) * HASH_MULT;
		end
		return acc;
	endfunction

	// The domain word is constant, so its part of the hash is folded here.
	localparam logic [31:0] HASH_PREFIX = fnv_word(HASH_BASIS, CHECK_DOMAIN);

	typedef struct packed {
		logic                  capture;
		logic                  hash_init;
		logic                  hash_step;
		logic [BYTE_SEL_W-1:0] byte_sel;
		logic                  finish;
	} casp_cmd_t;

	typedef struct packed {
		logic need_hash;
	} casp_sts_t;

endpackage
`default_nettype wire

### hw/rtl/clock_anchor_sideband_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted item passes decode and finish before its result is registered;
// checksum and commit settings also run a hash step for each of the 16 run-time FNV
// bytes, which go through one shared multiplier, one byte per cycle.
// Flow: one item at a time; the next item is taken the cycle after the
// result has left the output register.
// Reset: arst_n clears the parser to idle, closed packet, empty anchor.
// ----------------------------------------------------------------------------
// clock_anchor_sideband_parser
// Parses packet marks, settings, service messages and consume-frame requests
// and checks a six-setting clock anchor sideband with FNV-1a and commit word.
// ----------------------------------------------------------------------------
module clock_anchor_sideband_parser
	import casp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write port: index 0 version word, 1 base index.
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	// Input item stream.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: setting_index [31:0], setting_value [63:32], expected_frame [95:64].
	input  wire logic [95:0]  s_axis_tdata,
	// tuser: req_type [2:0].
	input  wire logic [2:0]   s_axis_tuser,
	// Result item stream.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: anchor_frame [30:0], anchor_time [94:31], anchor_check [126:95],
	// zero fill [127].
	output logic [127:0]      m_axis_tdata,
	// tuser: status [3:0].
	output logic [3:0]        m_axis_tuser
);

	casp_cmd_t   cmd;
	casp_sts_t   sts;
	logic [30:0] anchor_frame;
	logic [63:0] anchor_time;
	logic [31:0] anchor_check;

	// The controller sequences each item: capture, decode, an optional
	// sixteen-step hash run, then a finish step that updates the parser state
	// and loads the result register.
	casp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration, the pending anchor and the hash
	// unit, and decides the status and the next parser state during the finish step.
	casp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_req      (s_axis_tuser),
		.in_index    (s_axis_tdata[31:0]),
		.in_value    (s_axis_tdata[63:32]),
		.in_expected (s_axis_tdata[95:64]),
		.cmd         (cmd),
		.sts         (sts),
		.out_status  (m_axis_tuser),
		.out_frame   (anchor_frame),
		.out_time    (anchor_time),
		.out_check   (anchor_check)
	);

	// The anchor fields are zero for every status other than frame matched.
	assign m_axis_tdata = {1'b0, anchor_check, anchor_time, anchor_frame};

endmodule
`default_nettype wire

### hw/rtl/casp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casp_ctrl
// Sequencer: captures an item, runs the byte-serial hash when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module casp_ctrl
	import casp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire casp_sts_t sts,
	output casp_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_HASH   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam logic [BYTE_SEL_W-1:0] CNT_LAST = BYTE_SEL_W'(HASH_BYTES - 1);

	logic [1:0]            state_q;
	logic [BYTE_SEL_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  accept;

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.capture   = accept;
	assign cmd.hash_init = (state_q == S_DECODE);
	assign cmd.hash_step = (state_q == S_HASH);
	assign cmd.byte_sel  = cnt_q;
	assign cmd.finish    = (state_q == S_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					cnt_q   <= '0;
					state_q <= sts.need_hash ? S_HASH : S_FINISH;
				end
				S_HASH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result is still held");

	a_hash_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HASH && cnt_q == CNT_LAST) |=> (state_q == S_FINISH))
		else $error("hash run did not end in finish");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result raised without a finish step");

endmodule
`default_nettype wire

### hw/rtl/casp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casp_dp
// Datapath: configuration, parser state, FNV-1a hash unit, decision logic
// and result register.
// ----------------------------------------------------------------------------
module casp_dp
	import casp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic [2:0]  in_req,
	input  wire logic [31:0] in_index,
	input  wire logic [31:0] in_value,
	input  wire logic [31:0] in_expected,
	input  wire casp_cmd_t   cmd,
	output casp_sts_t        sts,
	output logic [3:0]       out_status,
	output logic [30:0]      out_frame,
	output logic [63:0]      out_time,
	output logic [31:0]      out_check
);

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	logic [30:0] schema_q;
	logic [31:0] base_q;

	logic [2:0]  phase_q;
	logic        open_q;
	logic [30:0] pend_frame_q;
	logic [63:0] pend_time_q;
	logic [31:0] pend_check_q;

	logic [2:0]  req_q;
	logic [31:0] idx_q;
	logic [31:0] val_q;
	logic [31:0] expf_q;

	logic [31:0] hash_q;
	logic [31:0] hash_word;
	logic [7:0]  hash_byte;
	logic [31:0] hash_mix;

	logic [31:0] off;
	logic [31:0] commit_word;

	logic [3:0]  n_status;
	logic [2:0]  n_phase;
	logic        n_open;
	logic [30:0] n_frame;
	logic [63:0] n_time;
	logic [31:0] n_check;
	logic        n_clear;
	logic        n_anchor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			schema_q <= 31'd1;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCHEMA: schema_q <= cfg_wdata[30:0];
				REG_BASE:   base_q   <= cfg_wdata;
				default:    base_q   <= base_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= in_req;
			idx_q  <= in_index;
			val_q  <= in_value;
			expf_q <= in_expected;
		end
	end

	// Hash unit: one byte per cycle over version, frame, time low and time high.
	always_comb begin
		case (cmd.byte_sel[3:2])
			2'd0:    hash_word = {1'b0, schema_q};
			2'd1:    hash_word = {1'b0, pend_frame_q};
			2'd2:    hash_word = pend_time_q[31:0];
			default: hash_word = pend_time_q[63:32];
		endcase
		hash_byte = hash_word[{cmd.byte_sel[1:0], 3'b000} +: 8];
		hash_mix  = hash_q ^ {24'b0, hash_byte};
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_init) begin
			hash_q <= HASH_PREFIX;
		end else if (cmd.hash_step) begin
			hash_q <= hash_mix * HASH_MULT;
		end
	end

	assign off = idx_q - base_q;
	assign commit_word = COMMIT_DOMAIN ^ rotl(pend_check_q, 7) ^
		rotl({1'b0, pend_frame_q}, 13) ^ rotl(pend_time_q[31:0], 19) ^
		rotl(pend_time_q[63:32], 3);

	assign sts.need_hash = (req_q == REQ_SETTING) && open_q &&
		(((off == OFF_CHECK) && (phase_q == PH_CHECK)) ||
		 ((off == OFF_COMMIT) && (phase_q == PH_COMMIT)));

	always_comb begin
		n_status = ST_INV_ARG;
		n_phase  = phase_q;
		n_open   = open_q;
		n_frame  = pend_frame_q;
		n_time   = pend_time_q;
		n_check  = pend_check_q;
		n_clear  = 1'b0;
		n_anchor = 1'b0;
		case (req_q)
			REQ_BEGIN: begin
				n_status = open_q ? ST_BOUNDARY : ST_STARTED;
				n_phase  = PH_IDLE;
				n_clear  = 1'b1;
				n_open   = 1'b1;
			end
			REQ_END: begin
				if (!open_q) begin
					n_status = ST_INV_STATE;
				end else begin
					n_status = (phase_q != PH_IDLE) ? ST_BOUNDARY : ST_ENDED;
					n_phase  = PH_IDLE;
					n_clear  = 1'b1;
					n_open   = 1'b0;
				end
			end
			REQ_SETTING: begin
				if (!open_q) begin
					n_status = ST_INV_STATE;
				end else if (off > OFF_LAST) begin
					if (phase_q == PH_IDLE) begin
						n_status = ST_NOT_SIDEBAND;
					end else begin
						n_status = ST_INTERVENING;
						n_phase  = PH_POISON;
						n_clear  = 1'b1;
					end
				end else if (phase_q == PH_POISON) begin
					n_status = ST_UNEXPECTED;
				end else if (off == '0) begin
					n_phase = PH_POISON;
					n_clear = 1'b1;
					if (phase_q != PH_IDLE) begin
						n_status = ST_UNEXPECTED;
					end else if (val_q != {1'b0, schema_q}) begin
						n_status = ST_BAD_VERSION;
					end else begin
						n_status = ST_ACCEPTED;
						n_phase  = PH_FRAME;
						n_clear  = 1'b0;
					end
				end else if (!(phase_q inside {[PH_FRAME:PH_COMMIT]}) ||
						off[2:0] != phase_q) begin
					n_status = ST_UNEXPECTED;
					n_phase  = PH_POISON;
					n_clear  = 1'b1;
				end else begin
					case (phase_q)
						PH_FRAME: begin
							if (val_q[31]) begin
								n_status = ST_UNEXPECTED;
								n_phase  = PH_POISON;
								n_clear  = 1'b1;
							end else begin
								n_status = ST_ACCEPTED;
								n_frame  = val_q[30:0];
								n_phase  = PH_TLO;
							end
						end
						PH_TLO: begin
							n_status = ST_ACCEPTED;
							n_time   = {32'b0, val_q};
							n_phase  = PH_THI;
						end
						PH_THI: begin
							n_status = ST_ACCEPTED;
							n_time   = {val_q, pend_time_q[31:0]};
							n_phase  = PH_CHECK;
						end
						PH_CHECK: begin
							if (val_q != hash_q) begin
								n_status = ST_CHECK_BAD;
								n_phase  = PH_POISON;
								n_clear  = 1'b1;
							end else begin
								n_status = ST_ACCEPTED;
								n_check  = val_q;
								n_phase  = PH_COMMIT;
							end
						end
						default: begin
							if (val_q != commit_word || pend_check_q != hash_q) begin
								n_status = ST_COMMIT_BAD;
								n_phase  = PH_POISON;
								n_clear  = 1'b1;
							end else begin
								n_status = ST_COMMITTED;
								n_phase  = PH_READY;
							end
						end
					endcase
				end
			end
			REQ_SERVICE: begin
				if (!open_q) begin
					n_status = ST_INV_STATE;
				end else if (phase_q == PH_IDLE) begin
					n_status = ST_NOT_SIDEBAND;
				end else begin
					n_status = ST_INTERVENING;
					n_phase  = PH_POISON;
					n_clear  = 1'b1;
				end
			end
			REQ_CONSUME: begin
				if (expf_q[31]) begin
					n_status = ST_INV_ARG;
				end else if (!open_q) begin
					n_status = ST_INV_STATE;
				end else if (phase_q != PH_READY) begin
					n_status = ST_MISSING;
					n_phase  = PH_POISON;
					n_clear  = 1'b1;
				end else if ({1'b0, pend_frame_q} != expf_q) begin
					n_status = ST_MISMATCH;
					n_phase  = PH_POISON;
					n_clear  = 1'b1;
				end else begin
					n_status = ST_MATCHED;
					n_anchor = 1'b1;
					n_phase  = PH_IDLE;
					n_clear  = 1'b1;
				end
			end
			default: begin
				n_status = ST_INV_ARG;
			end
		endcase
		if (n_clear) begin
			n_frame = '0;
			n_time  = '0;
			n_check = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			open_q       <= 1'b0;
			pend_frame_q <= '0;
			pend_time_q  <= '0;
			pend_check_q <= '0;
		end else if (cmd.finish) begin
			phase_q      <= n_phase;
			open_q       <= n_open;
			pend_frame_q <= n_frame;
			pend_time_q  <= n_time;
			pend_check_q <= n_check;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status <= n_status;
			out_frame  <= n_anchor ? pend_frame_q : '0;
			out_time   <= n_anchor ? pend_time_q : '0;
			out_check  <= n_anchor ? pend_check_q : '0;
		end
	end

endmodule
`default_nettype wire
